@@ sv/cdl_pkg.sv @@
// ----------------------------------------------------------------------------
// cdl_pkg: shared types and constants of the climate drive law
// Register map, span constants, reciprocal constants and the stage record
// that travels between the front and back halves of the datapath.
// ----------------------------------------------------------------------------
package cdl_pkg;

  // field widths
  localparam int unsigned TempW    = 12;
  localparam int unsigned HumW     = 11;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  // law constants: spans and hysteresis in 1/16 units, boost in duty steps
  localparam int unsigned FanTempSpan = 160;
  localparam int unsigned FanHumSpan  = 800;
  localparam int unsigned HeatSpan    = 32;
  localparam int unsigned Hyst        = 32;
  localparam int unsigned FanBoost    = 50;

  // products are pre-shifted by 5 (divide by 32), then scaled by a reciprocal
  localparam int unsigned SpanShift        = 5;
  localparam int unsigned RecipFive        = 1639;  // ceil(2^13 / 5)
  localparam int unsigned RecipFiveShift   = 13;
  localparam int unsigned RecipQuarterC    = 5243;  // ceil(2^17 / 25)
  localparam int unsigned RecipQuarterCSh  = 17;

  localparam int unsigned FanProdW  = 18;  // 255 * 800 < 2^18
  localparam int unsigned HeatProdW = 13;  // 255 * 32 < 2^13

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP_TARGET    = 3'd0,
    REG_HUM_TARGET     = 3'd1,
    REG_COLD_THRESHOLD = 3'd2,
    REG_FAN_DUTY_MIN   = 3'd3,
    REG_FAN_DUTY_MAX   = 3'd4,
    REG_HEAT_DUTY_MIN  = 3'd5,
    REG_HEAT_DUTY_MAX  = 3'd6
  } cdl_reg_e;

  // which rule drives the fan
  typedef enum logic [1:0] {
    FAN_IDLE = 2'd0,
    FAN_TEMP = 2'd1,
    FAN_HUM  = 2'd2
  } cdl_fan_mode_e;

  typedef struct packed {
    logic signed [TempW-1:0] temp_target;
    logic [HumW-1:0]         hum_target;
    logic [DutyW-1:0]        cold_threshold;
    logic [DutyW-1:0]        fan_duty_min;
    logic [DutyW-1:0]        fan_duty_max;
    logic [DutyW-1:0]        heat_duty_min;
    logic [DutyW-1:0]        heat_duty_max;
  } cdl_cfg_t;

  // record between the product stage and the scaling stage
  typedef struct packed {
    logic                 ok;
    cdl_fan_mode_e        fan_mode;
    logic                 boost;
    logic                 fan_neg;
    logic [FanProdW-1:0]  fan_prod;
    logic                 heat_on;
    logic                 heat_neg;
    logic [HeatProdW-1:0] heat_prod;
    logic                 hum_on;
  } cdl_prod_t;

endpackage

@@ sv/cdl_front.sv @@
// ----------------------------------------------------------------------------
// cdl_front: error terms, rule selection and span products
// Works out the temperature and humidity errors of one sample, picks the
// fan rule, the heater enable and the new humidifier state, and forms the
// magnitude products of each interpolation.
// ----------------------------------------------------------------------------
module cdl_front (
  input  logic                                sample_ok_i,
  input  logic signed [cdl_pkg::TempW-1:0]    temp_now_i,
  input  logic [cdl_pkg::HumW-1:0]            hum_now_i,
  input  cdl_pkg::cdl_cfg_t                   cfg_i,
  input  logic                                humid_state_i,
  output cdl_pkg::cdl_prod_t                  prod_o
);
  import cdl_pkg::*;

  logic signed [TempW:0]   temp_diff;
  logic signed [TempW:0]   deficit;
  logic signed [HumW:0]    hum_diff;
  logic signed [HumW:0]    hum_short;
  logic signed [HumW:0]    hyst_lim;
  logic                    temp_hot;
  logic                    hum_wet;
  logic                    below_cold;
  logic                    fan_temp;
  logic                    fan_hum;
  logic [7:0]              temp_amt;
  logic [9:0]              hum_amt;
  logic [9:0]              fan_amt;
  logic [5:0]              heat_amt;
  logic signed [DutyW:0]   fan_span;
  logic signed [DutyW:0]   fan_span_n;
  logic signed [DutyW:0]   heat_span;
  logic signed [DutyW:0]   heat_span_n;
  logic [DutyW-1:0]        fan_mag;
  logic [DutyW-1:0]        heat_mag;

  // error terms
  assign temp_diff = {temp_now_i[TempW-1], temp_now_i}
                   - {cfg_i.temp_target[TempW-1], cfg_i.temp_target};
  assign deficit   = -temp_diff;
  assign hum_diff  = {1'b0, hum_now_i} - {1'b0, cfg_i.hum_target};
  assign hum_short = -hum_diff;

  // hysteresis limit as a signed value so the band compares stay signed
  assign hyst_lim = $signed((HumW+1)'(Hyst));

  assign temp_hot   = temp_diff > (TempW+1)'(0);
  assign hum_wet    = hum_diff > (HumW+1)'(0);
  assign below_cold = deficit < $signed({5'b0, cfg_i.cold_threshold});

  // fan rule selection
  assign fan_temp = sample_ok_i && temp_hot;
  assign fan_hum  = sample_ok_i && !temp_hot && hum_wet && below_cold;

  // clamped amounts
  assign temp_amt = (temp_diff > (TempW+1)'(FanTempSpan)) ? 8'(FanTempSpan)
                                                          : temp_diff[7:0];
  assign hum_amt  = (hum_diff > (HumW+1)'(FanHumSpan)) ? 10'(FanHumSpan)
                                                       : hum_diff[9:0];
  assign fan_amt  = fan_temp ? {2'b0, temp_amt} : hum_amt;
  assign heat_amt = (deficit > (TempW+1)'(HeatSpan)) ? 6'(HeatSpan) : deficit[5:0];

  // span magnitudes, direction kept apart
  assign fan_span    = $signed({1'b0, cfg_i.fan_duty_max}) - $signed({1'b0, cfg_i.fan_duty_min});
  assign fan_span_n  = -fan_span;
  assign fan_mag     = fan_span[DutyW] ? fan_span_n[DutyW-1:0] : fan_span[DutyW-1:0];
  assign heat_span   = $signed({1'b0, cfg_i.heat_duty_max})
                     - $signed({1'b0, cfg_i.heat_duty_min});
  assign heat_span_n = -heat_span;
  assign heat_mag    = heat_span[DutyW] ? heat_span_n[DutyW-1:0] : heat_span[DutyW-1:0];

  // record for the scaling stage
  always_comb begin
    prod_o.ok        = sample_ok_i;
    prod_o.fan_mode  = fan_temp ? FAN_TEMP : (fan_hum ? FAN_HUM : FAN_IDLE);
    prod_o.boost     = fan_hum && (hum_diff > hyst_lim) && !humid_state_i;
    prod_o.fan_neg   = fan_span[DutyW];
    prod_o.fan_prod  = FanProdW'(fan_mag) * FanProdW'(fan_amt);
    prod_o.heat_on   = sample_ok_i && !below_cold;
    prod_o.heat_neg  = heat_span[DutyW];
    prod_o.heat_prod = HeatProdW'(heat_mag) * HeatProdW'(heat_amt);
    prod_o.hum_on    = humid_state_i;
    if (sample_ok_i) begin
      if (hum_short > hyst_lim) begin
        prod_o.hum_on = 1'b1;
      end else if (hum_diff > hyst_lim) begin
        prod_o.hum_on = 1'b0;
      end
    end
  end

endmodule

@@ sv/cdl_back.sv @@
// ----------------------------------------------------------------------------
// cdl_back: span scaling and duty assembly
// Divides the span products by their spans through reciprocal multiplies,
// applies direction, boost, cap and saturation, and gives both duties.
// ----------------------------------------------------------------------------
module cdl_back (
  input  cdl_pkg::cdl_prod_t               prod_i,
  input  cdl_pkg::cdl_cfg_t                cfg_i,
  output logic [cdl_pkg::DutyW-1:0]        fan_duty_o,
  output logic [cdl_pkg::DutyW-1:0]        heat_duty_o
);
  import cdl_pkg::*;

  function automatic logic [DutyW-1:0] sat8(input logic signed [DutyW+1:0] v);
    logic [DutyW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > (DutyW+2)'(255)) begin
      r = '1;
    end else begin
      r = v[DutyW-1:0];
    end
    return r;
  endfunction

  logic [FanProdW-SpanShift-1:0] fan_pre;
  logic [23:0]                   temp_mul;
  logic [25:0]                   hum_mul;
  logic [DutyW-1:0]              fan_q;
  logic signed [DutyW+1:0]       fan_step;
  logic signed [DutyW+1:0]       fan_lerp;
  logic signed [DutyW+1:0]       fan_boosted;
  logic signed [DutyW+1:0]       fan_capped;
  logic signed [DutyW+1:0]       fan_val;
  logic [DutyW-1:0]              heat_q;
  logic signed [DutyW+1:0]       heat_step;
  logic signed [DutyW+1:0]       heat_val;

  // fan: divide by 160 or 800 as (p >> 5) / 5 or / 25
  assign fan_pre  = prod_i.fan_prod[FanProdW-1:SpanShift];
  assign temp_mul = 24'(fan_pre) * 24'(RecipFive);
  assign hum_mul  = 26'(fan_pre) * 26'(RecipQuarterC);
  assign fan_q    = (prod_i.fan_mode == FAN_TEMP) ? temp_mul[RecipFiveShift +: DutyW]
                                                  : hum_mul[RecipQuarterCSh +: DutyW];

  // interpolation toward the max, truncated toward zero
  assign fan_step    = prod_i.fan_neg ? -$signed({2'b0, fan_q}) : $signed({2'b0, fan_q});
  assign fan_lerp    = $signed({2'b0, cfg_i.fan_duty_min}) + fan_step;
  assign fan_boosted = fan_lerp + (DutyW+2)'(FanBoost);
  assign fan_capped  = (fan_boosted < $signed({2'b0, cfg_i.fan_duty_max})) ? fan_boosted
                                                   : $signed({2'b0, cfg_i.fan_duty_max});

  always_comb begin
    case (prod_i.fan_mode)
      FAN_TEMP: fan_val = fan_lerp;
      FAN_HUM:  fan_val = prod_i.boost ? fan_capped : fan_lerp;
      default:  fan_val = $signed({2'b0, cfg_i.fan_duty_min});
    endcase
  end

  assign fan_duty_o = sat8(fan_val);

  // heater: span of 32 is a plain shift
  assign heat_q    = prod_i.heat_prod[HeatProdW-1:SpanShift];
  assign heat_step = prod_i.heat_neg ? -$signed({2'b0, heat_q}) : $signed({2'b0, heat_q});
  assign heat_val  = $signed({2'b0, cfg_i.heat_duty_min}) + heat_step;

  assign heat_duty_o = prod_i.heat_on ? sat8(heat_val) : '0;

endmodule

@@ sv/climate_drive_law.sv @@
// ----------------------------------------------------------------------------
// climate_drive_law: fan, heater and humidifier law for one sensor sample
// Three register stages: input, span products, result.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while results are taken; each stage moves whenever the next frees.
// The humidifier state is updated as a sample leaves the input stage, so the
// next sample sees the updated state with no wait.
// Reset: pipeline emptied, registers at their defaults, humidifier off.
// ----------------------------------------------------------------------------
module climate_drive_law (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [cdl_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [cdl_pkg::CfgDataW-1:0]       cfg_data_i,
  // sample stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [cdl_pkg::InDataW-1:0]        s_axis_tdata,  // temp_now, hum_now, zero pad
  input  logic                               s_axis_tuser,  // sample_ok
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [cdl_pkg::OutDataW-1:0]       m_axis_tdata   // fan_duty, heat_duty,
                                                            // humidifier_on, zero pad
);
  import cdl_pkg::*;

  cdl_cfg_t               cfg_q;
  logic                   humid_q;

  logic                   in_valid_q, in_valid_d;
  logic                   in_ok_q;
  logic signed [TempW-1:0] in_temp_q;
  logic [HumW-1:0]        in_hum_q;

  logic                   prod_valid_q, prod_valid_d;
  cdl_prod_t              prod_d, prod_q;

  logic                   out_valid_q, out_valid_d;
  logic [DutyW-1:0]       fan_d, fan_q;
  logic [DutyW-1:0]       heat_d, heat_q;
  logic                   hum_out_q;

  logic                   in_xfer;
  logic                   out_free;
  logic                   prod_adv;
  logic                   prod_free;
  logic                   in_adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_target    <= TempW'(320);
      cfg_q.hum_target     <= HumW'(1040);
      cfg_q.cold_threshold <= DutyW'(8);
      cfg_q.fan_duty_min   <= DutyW'(80);
      cfg_q.fan_duty_max   <= DutyW'(255);
      cfg_q.heat_duty_min  <= DutyW'(0);
      cfg_q.heat_duty_max  <= DutyW'(255);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEMP_TARGET:    cfg_q.temp_target    <= cfg_data_i[TempW-1:0];
        REG_HUM_TARGET:     cfg_q.hum_target     <= cfg_data_i[HumW-1:0];
        REG_COLD_THRESHOLD: cfg_q.cold_threshold <= cfg_data_i[DutyW-1:0];
        REG_FAN_DUTY_MIN:   cfg_q.fan_duty_min   <= cfg_data_i[DutyW-1:0];
        REG_FAN_DUTY_MAX:   cfg_q.fan_duty_max   <= cfg_data_i[DutyW-1:0];
        REG_HEAT_DUTY_MIN:  cfg_q.heat_duty_min  <= cfg_data_i[DutyW-1:0];
        REG_HEAT_DUTY_MAX:  cfg_q.heat_duty_max  <= cfg_data_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign prod_adv      = prod_valid_q && out_free;
  assign prod_free     = !prod_valid_q || prod_adv;
  assign in_adv        = in_valid_q && prod_free;
  assign s_axis_tready = !in_valid_q || in_adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d   = in_xfer || (in_valid_q && !in_adv);
  assign prod_valid_d = in_adv || (prod_valid_q && !prod_adv);
  assign out_valid_d  = prod_adv || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      humid_q      <= 1'b0;
    end else begin
      in_valid_q   <= in_valid_d;
      prod_valid_q <= prod_valid_d;
      out_valid_q  <= out_valid_d;
      if (in_adv) begin
        humid_q <= prod_d.hum_on;
      end
    end
  end

  // input stage
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_ok_q   <= s_axis_tuser;
      in_temp_q <= s_axis_tdata[TempW-1:0];
      in_hum_q  <= s_axis_tdata[TempW +: HumW];
    end
  end

  cdl_front u_front (
    .sample_ok_i   (in_ok_q),
    .temp_now_i    (in_temp_q),
    .hum_now_i     (in_hum_q),
    .cfg_i         (cfg_q),
    .humid_state_i (humid_q),
    .prod_o        (prod_d)
  );

  // product stage
  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      prod_q <= prod_d;
    end
  end

  cdl_back u_back (
    .prod_i      (prod_q),
    .cfg_i       (cfg_q),
    .fan_duty_o  (fan_d),
    .heat_duty_o (heat_d)
  );

  // result stage
  always_ff @(posedge clk_i) begin
    if (prod_adv) begin
      fan_q     <= fan_d;
      heat_q    <= heat_d;
      hum_out_q <= prod_q.hum_on;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - 2*DutyW - 1){1'b0}}, hum_out_q, heat_q, fan_q};

  // humidifier state only moves when a sample leaves the input stage
  a_humid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_adv |=> $stable(humid_q))
    else $error("humidifier state changed without a sample");

  // a new result only comes from a filled product stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(prod_valid_q))
    else $error("result appeared without a product stage item");

  // an empty input stage always takes a transfer
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("empty input stage not ready");

  // a failed sample drives no fan rule and no heater
  a_bad_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prod_valid_q && !prod_q.ok) |-> (prod_q.fan_mode == FAN_IDLE && !prod_q.heat_on))
    else $error("failed sample selected a drive rule");

  // the boost applies to the humidity rule only
  a_boost_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prod_valid_q && prod_q.boost) |-> (prod_q.fan_mode == FAN_HUM))
    else $error("fan boost outside the humidity rule");

endmodule

@@ tb/drive_law_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_law_checker: result checker for the climate drive law
// Follows register writes and sample transfers, predicts the fan, heater and
// humidifier command of every sample from its own copy of the registers and
// the humidifier state, and compares each result transfer field by field
// with the oldest predicted command.
// ----------------------------------------------------------------------------
module drive_law_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cdl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cdl_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [cdl_pkg::InDataW-1:0]  s_tdata_i,   // temp_now, hum_now, zero pad
  input  logic                         s_tuser_i,   // sample_ok
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [cdl_pkg::OutDataW-1:0] m_tdata_i,   // fan_duty, heat_duty, humidifier_on,
                                                    // zero pad
  output int                           fail_count_o,
  output int                           pending_o
);
  import cdl_pkg::*;

  // signed copies of the law constants, so no comparison turns unsigned
  localparam int TempSpanI = int'(FanTempSpan);
  localparam int HumSpanI  = int'(FanHumSpan);
  localparam int HeatSpanI = int'(HeatSpan);
  localparam int HystI     = int'(Hyst);
  localparam int BoostI    = int'(FanBoost);

  // result field positions
  localparam int HeatLsb  = DutyW;
  localparam int HumOnBit = 2 * DutyW;
  localparam int PadLsb   = 2 * DutyW + 1;

  localparam int PrintLimit = 50;

  localparam cdl_cfg_t CfgAtReset = '{
    temp_target:    12'sd320,
    hum_target:     11'd1040,
    cold_threshold: 8'd8,
    fan_duty_min:   8'd80,
    fan_duty_max:   8'd255,
    heat_duty_min:  8'd0,
    heat_duty_max:  8'd255
  };

  typedef struct packed {
    logic [DutyW-1:0] fan_duty;
    logic [DutyW-1:0] heat_duty;
    logic             humidifier_on;
  } drive_cmd_t;

  cdl_cfg_t   shadow_cfg;
  logic       humid_state;
  drive_cmd_t pending_cmds[$];
  int         mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  // straight line from lo toward hi, amount clipped at full, truncated to zero
  function automatic int span_scale(input int lo, input int hi, input int amount,
                                    input int full);
    int clipped;
    clipped = (amount > full) ? full : amount;
    return lo + ((hi - lo) * clipped) / full;
  endfunction

  function automatic logic [DutyW-1:0] clamp_duty(input int value);
    if (value < 0) return '0;
    if (value > 255) return '1;
    return DutyW'(value);
  endfunction

  // fan, heater and humidifier command for one sample
  function automatic drive_cmd_t compute_drive_cmd(input logic ok,
                                                   input logic [TempW-1:0] temp_bits,
                                                   input logic [HumW-1:0] hum_bits,
                                                   input cdl_cfg_t c,
                                                   input logic humid_prev);
    int         temp_now, hum_now, td, hd, deficit, fan, heat;
    int         fmin, fmax, cold;
    logic       humid_next;
    drive_cmd_t cmd;
    temp_now   = int'($signed(temp_bits));
    hum_now    = int'(hum_bits);
    fmin       = int'(c.fan_duty_min);
    fmax       = int'(c.fan_duty_max);
    cold       = int'(c.cold_threshold);
    fan        = fmin;
    heat       = 0;
    humid_next = humid_prev;
    if (ok) begin
      td      = temp_now - int'($signed(c.temp_target));
      hd      = hum_now - int'(c.hum_target);
      deficit = -td;
      // overtemperature wins, else excess humidity unless it is too cold
      if (td > 0) begin
        fan = span_scale(fmin, fmax, td, TempSpanI);
      end else if (hd > 0 && deficit < cold) begin
        fan = span_scale(fmin, fmax, hd, HumSpanI);
        // boost uses the humidifier state held before this sample
        if (hd > HystI && !humid_prev) begin
          fan = (fan + BoostI < fmax) ? fan + BoostI : fmax;
        end
      end
      if (deficit >= cold) begin
        heat = span_scale(int'(c.heat_duty_min), int'(c.heat_duty_max), deficit, HeatSpanI);
      end
      // hysteresis band around the humidity target
      if (-hd > HystI) begin
        humid_next = 1'b1;
      end else if (hd > HystI) begin
        humid_next = 1'b0;
      end
    end
    cmd.fan_duty      = clamp_duty(fan);
    cmd.heat_duty     = clamp_duty(heat);
    cmd.humidifier_on = humid_next;
    return cmd;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PrintLimit) begin
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    drive_cmd_t got, want;
    if (!rst_ni) begin
      shadow_cfg  = CfgAtReset;
      humid_state = 1'b0;
      pending_cmds.delete();
      pending_o   <= 0;
    end else begin
      // result transfer against the oldest predicted command
      if (m_tvalid_i && m_tready_i) begin
        got.fan_duty      = m_tdata_i[DutyW-1:0];
        got.heat_duty     = m_tdata_i[HeatLsb +: DutyW];
        got.humidifier_on = m_tdata_i[HumOnBit];
        if (pending_cmds.size() == 0) begin
          report_mismatch("unrequested result", int'(m_tdata_i), 0);
        end else begin
          want = pending_cmds.pop_front();
          if (got.fan_duty != want.fan_duty)
            report_mismatch("fan_duty", got.fan_duty, want.fan_duty);
          if (got.heat_duty != want.heat_duty)
            report_mismatch("heat_duty", got.heat_duty, want.heat_duty);
          if (got.humidifier_on != want.humidifier_on)
            report_mismatch("humidifier_on", got.humidifier_on, want.humidifier_on);
        end
        if (m_tdata_i[OutDataW-1:PadLsb] != '0)
          report_mismatch("tdata pad", int'(m_tdata_i[OutDataW-1:PadLsb]), 0);
      end

      // sample transfer: predict and advance the humidifier state
      if (s_tvalid_i && s_tready_i) begin
        want = compute_drive_cmd(s_tuser_i, s_tdata_i[TempW-1:0], s_tdata_i[TempW +: HumW],
                                 shadow_cfg, humid_state);
        humid_state = want.humidifier_on;
        pending_cmds.push_back(want);
      end

      // register writes, unknown indexes are dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TEMP_TARGET:    shadow_cfg.temp_target    = cfg_data_i[TempW-1:0];
          REG_HUM_TARGET:     shadow_cfg.hum_target     = cfg_data_i[HumW-1:0];
          REG_COLD_THRESHOLD: shadow_cfg.cold_threshold = cfg_data_i[DutyW-1:0];
          REG_FAN_DUTY_MIN:   shadow_cfg.fan_duty_min   = cfg_data_i[DutyW-1:0];
          REG_FAN_DUTY_MAX:   shadow_cfg.fan_duty_max   = cfg_data_i[DutyW-1:0];
          REG_HEAT_DUTY_MIN:  shadow_cfg.heat_duty_min  = cfg_data_i[DutyW-1:0];
          REG_HEAT_DUTY_MAX:  shadow_cfg.heat_duty_max  = cfg_data_i[DutyW-1:0];
          default: ;
        endcase
      end

      pending_o <= pending_cmds.size();
    end
  end

endmodule

@@ tb/climate_drive_law_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// climate_drive_law_test: stimulus and verdict for the climate drive law
// Runs a directed set of samples at the reset settings, then random samples
// under a series of register settings that include the range extremes, an
// inverted duty range and raw bit-pattern extremes. Both stream sides idle
// at random and the result side holds off once for long enough to back the
// pipeline up. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module climate_drive_law_test;
  import cdl_pkg::*;

  localparam int PhaseCount    = 12;
  localparam int ItemsPerPhase = 125;
  localparam int PressurePhase = 2;
  localparam int PressureHold  = 100;
  localparam int DrainCycles   = 4;
  localparam int IdleLimit     = 1000;

  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int       fail_count;
  int       pending;
  int       phase_no      = 0;
  int       burst_left    = 0;
  int       idle_cycles   = 0;
  logic     pressure_done = 1'b0;
  cdl_cfg_t cur = '{
    temp_target:    12'sd320,
    hum_target:     11'd1040,
    cold_threshold: 8'd8,
    fan_duty_min:   8'd80,
    fan_duty_max:   8'd255,
    heat_duty_min:  8'd0,
    heat_duty_max:  8'd255
  };

  climate_drive_law DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  drive_law_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // offer one sample after a random gap and wait for its transfer
  task automatic send_sample(input logic ok, input logic [TempW-1:0] temp,
                             input logic [HumW-1:0] hum);
    int gap, pick;
    pick = $urandom_range(0, 99);
    if (burst_left > 0 || phase_no == PressurePhase) begin
      gap = 0;
    end else if (pick < 50) begin
      gap = 0;
    end else if (pick < 85) begin
      gap = $urandom_range(1, 3);
    end else if (pick < 96) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(11, 30);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 40) == 0) begin
      burst_left = $urandom_range(16, 48);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, hum, temp};
    s_axis_tuser  <= ok;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // all predicted results in, then an idle stretch of DrainCycles
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write every register, junk in the unused upper data bits of all but the temperature target
  task automatic apply_settings(input cdl_cfg_t s);
    cdl_reg_e r;
    r = r.first();
    repeat (r.num()) begin
      cfg_we_i  <= 1'b1;
      cfg_idx_i <= r;
      case (r)
        REG_TEMP_TARGET:    cfg_data_i <= s.temp_target;
        REG_HUM_TARGET:     cfg_data_i <= {1'($urandom()), s.hum_target};
        REG_COLD_THRESHOLD: cfg_data_i <= {4'($urandom()), s.cold_threshold};
        REG_FAN_DUTY_MIN:   cfg_data_i <= {4'($urandom()), s.fan_duty_min};
        REG_FAN_DUTY_MAX:   cfg_data_i <= {4'($urandom()), s.fan_duty_max};
        REG_HEAT_DUTY_MIN:  cfg_data_i <= {4'($urandom()), s.heat_duty_min};
        REG_HEAT_DUTY_MAX:  cfg_data_i <= {4'($urandom()), s.heat_duty_max};
        default:            cfg_data_i <= '0;
      endcase
      @(posedge clk_i);
      r = r.next();
    end
    // a write to the unused index must change nothing
    cfg_idx_i  <= RegSpare;
    cfg_data_i <= 12'($urandom());
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur = s;
  endtask

  // result side: random stalls, ready runs, one long hold-off
  initial begin
    int pick, hold;
    @(posedge clk_i);
    forever begin
      if (phase_no == PressurePhase && !pressure_done) begin
        pressure_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (PressureHold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 99) < 25) begin
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        hold = $urandom_range(1, 3);
      end else if (pick < 92) begin
        hold = $urandom_range(4, 12);
      end else begin
        hold = $urandom_range(13, 40);
      end
      m_axis_tready <= 1'b0;
      repeat (hold) @(posedge clk_i);
    end
  end

  // watchdog on cycles without any transfer or register write
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("climate_drive_law_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    cdl_cfg_t         s;
    logic             ok;
    logic [TempW-1:0] temp;
    logic [HumW-1:0]  hum;
    int               pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < PhaseCount; p++) begin
      if (p > 0) begin
        wait_drained();
        case (p)
          // range lows, all but the temperature target flat at zero
          1: s = '{-12'sd640, 11'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
          // range highs
          2: s = '{12'sd2000, 11'd1600, 8'd160, 8'd255, 8'd255, 8'd255, 8'd255};
          // maximum below minimum on both duties
          3: s = '{12'sd320, 11'd1040, 8'd8, 8'd255, 8'd0, 8'd200, 8'd10};
          // raw bit-pattern extremes
          4: s = '{12'sh800, 11'h7ff, 8'd255, 8'd255, 8'd1, 8'd255, 8'd0};
          5: s = '{12'sh7ff, 11'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255};
          // fully random bits
          11: s = cdl_cfg_t'($urandom());
          default: begin
            s.temp_target    = 12'(int'($urandom_range(0, 2640)) - 640);
            s.hum_target     = 11'($urandom_range(0, 1600));
            s.cold_threshold = 8'($urandom_range(0, 160));
            s.fan_duty_min   = 8'($urandom());
            s.fan_duty_max   = 8'($urandom());
            s.heat_duty_min  = 8'($urandom());
            s.heat_duty_max  = 8'($urandom());
          end
        endcase
        if (p == 11) begin
          s.temp_target = 12'($urandom());
          s.hum_target  = 11'($urandom());
        end
        apply_settings(s);
      end
      // new phase starts once the pipeline is empty and the registers are set
      phase_no = p;
      if (p == 0) begin
        // directed samples at the reset settings (320, 1040, cold 8)
        send_sample(1'b0, 12'h7ff, 11'd0);     // invalid sample, state kept
        send_sample(1'b1, 12'h800, 11'h7ff);   // coldest reading, wettest, off
        send_sample(1'b1, 12'h7ff, 11'd0);     // hottest reading, humidifier on
        send_sample(1'b1, 12'd321, 11'd1040);  // just over temperature
        send_sample(1'b1, 12'd480, 11'd1040);  // full temperature span
        send_sample(1'b1, 12'd481, 11'd1040);  // past the span
        send_sample(1'b1, 12'd320, 11'd1041);  // slight excess humidity
        send_sample(1'b1, 12'd320, 11'd1072);  // edge of the band, no change
        send_sample(1'b1, 12'd320, 11'd1073);  // leaves band, no boost while on
        send_sample(1'b1, 12'd320, 11'd1073);  // boost now that it is off
        send_sample(1'b1, 12'd320, 11'd1840);  // full humidity span, boost capped
        send_sample(1'b1, 12'd313, 11'd1100);  // deficit just under the threshold
        send_sample(1'b1, 12'd312, 11'd1100);  // deficit at the threshold
        send_sample(1'b1, 12'd288, 11'd1040);  // full heater span
        send_sample(1'b1, 12'd100, 11'd1040);  // far past the heater span
        send_sample(1'b1, 12'd320, 11'd1008);  // lower band edge, no change
        send_sample(1'b1, 12'd320, 11'd1007);  // below band, humidifier on
        send_sample(1'b0, 12'd0, 11'h7ff);     // invalid while on
        send_sample(1'b1, 12'd0, 11'd0);
        send_sample(1'b0, 12'h800, 11'h7ff);
      end

      // random samples, mostly around the current targets
      repeat (ItemsPerPhase) begin
        ok   = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          temp = 12'(int'($signed(cur.temp_target)) + int'($urandom_range(0, 400)) - 200);
        end else if (pick < 85) begin
          temp = 12'(int'($signed(cur.temp_target)) + int'($urandom_range(0, 80)) - 40);
        end else begin
          temp = 12'($urandom());
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          hum = 11'(int'(cur.hum_target) + int'($urandom_range(0, 1800)) - 900);
        end else if (pick < 85) begin
          hum = 11'(int'(cur.hum_target) + int'($urandom_range(0, 80)) - 40);
        end else begin
          hum = 11'($urandom());
        end
        send_sample(ok, temp, hum);
      end
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("climate_drive_law_test OK");
    end else begin
      $display("climate_drive_law_test NOT OK");
    end
    $finish;
  end

endmodule
